>>> hdl/lirs_pkg.sv
package lirs_pkg;

    localparam int RATE_W      = 18;
    localparam int SMP_W       = 16;
    localparam int MAX_BLOCK   = 4096;
    localparam int IDX_W       = $clog2(MAX_BLOCK);
    localparam int LIM_W       = IDX_W + 1;
    localparam int POS_W       = 20;
    localparam int HOLD_DEPTH  = 4;
    localparam int HOLD_IW     = $clog2(HOLD_DEPTH);
    localparam int HOLD_CW     = $clog2(HOLD_DEPTH + 1);
    localparam int ITER_W      = 5;
    localparam int PROD_W      = SMP_W + RATE_W;
    localparam int MAX_UPSAMPLE = 24;

    localparam logic [RATE_W-1:0] RATE_RESET       = RATE_W'(48000);
    localparam logic [ITER_W-1:0] DIV_STEP_ITERS   = ITER_W'(RATE_W);
    localparam logic [ITER_W-1:0] DIV_INTERP_ITERS = ITER_W'(SMP_W);

    localparam int REG_SENDER_RATE = 0;
    localparam int REG_OUTPUT_RATE = 1;

    typedef struct packed {
        logic [POS_W-1:0]  w;
        logic [RATE_W-1:0] r;
    } pos_t;

    typedef struct packed {
        logic              start;
        logic [RATE_W-1:0] rem_init;
        logic [RATE_W-1:0] dividend;
        logic [ITER_W-1:0] iters;
        logic [RATE_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              wr;
        logic [RATE_W-1:0] sender_rate;
        logic [RATE_W-1:0] output_rate;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RC_EFF,
        ST_RC_DIV,
        ST_RC_WAIT,
        ST_DR_A,
        ST_DR_B,
        ST_DR_C,
        ST_CK_A,
        ST_CK_B,
        ST_MUL,
        ST_DIV,
        ST_DIV_WAIT
    } state_t;

    function automatic pos_t pos_advance(pos_t p, logic [RATE_W-1:0] sw,
                                         logic [RATE_W-1:0] sr,
                                         logic [RATE_W-1:0] den);
        logic [RATE_W:0] rs;
        pos_t q;
        rs = {1'b0, p.r} + {1'b0, sr};
        if (rs >= {1'b0, den})
        begin
            q.r = RATE_W'(rs - {1'b0, den});
            q.w = p.w + POS_W'(sw) + POS_W'(1);
        end
        else
        begin
            q.r = rs[RATE_W-1:0];
            q.w = p.w + POS_W'(sw);
        end
        return q;
    endfunction

    function automatic logic pos_fits(pos_t p, logic [LIM_W-1:0] lim);
        return (p.w < POS_W'(lim)) || ((p.w == POS_W'(lim)) && (p.r == '0));
    endfunction

endpackage

>>> hdl/lirs_div.sv
module lirs_div
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  lirs_pkg::div_req_t               req,
    output logic                             done,
    output logic [lirs_pkg::RATE_W-1:0]      quot,
    output logic [lirs_pkg::RATE_W-1:0]      rem
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [lirs_pkg::ITER_W-1:0]   cnt_reg, cnt_next;
    logic [lirs_pkg::RATE_W-1:0]   rem_reg, rem_next;
    logic [lirs_pkg::RATE_W-1:0]   dvd_reg, dvd_next;
    logic [lirs_pkg::RATE_W-1:0]   quot_reg, quot_next;
    logic [lirs_pkg::RATE_W:0]     trial;
    logic [lirs_pkg::RATE_W:0]     trial_sub;
    logic                          ge;

    always_comb
    begin
        trial     = {rem_reg, dvd_reg[lirs_pkg::RATE_W-1]};
        ge        = trial >= {1'b0, req.divisor};
        trial_sub = trial - {1'b0, req.divisor};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        quot_next = quot_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = req.iters;
            rem_next  = req.rem_init;
            dvd_next  = req.dividend;
            quot_next = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? trial_sub[lirs_pkg::RATE_W-1:0] : trial[lirs_pkg::RATE_W-1:0];
            dvd_next  = {dvd_reg[lirs_pkg::RATE_W-2:0], 1'b0};
            quot_next = {quot_reg[lirs_pkg::RATE_W-2:0], ge};
            cnt_next  = cnt_reg - lirs_pkg::ITER_W'(1);
            if (cnt_reg == lirs_pkg::ITER_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            dvd_reg  <= '0;
            quot_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
            dvd_reg  <= dvd_next;
            quot_reg <= quot_next;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

>>> hdl/lirs_ctrl.sv
module lirs_ctrl
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  lirs_pkg::cfg_t                 cfg,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [lirs_pkg::SMP_W-1:0]     in_sample,
    input  logic                           in_end,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [lirs_pkg::SMP_W-1:0]     out_sample,
    output logic                           out_last
);

    lirs_pkg::state_t              state_reg, state_next;
    lirs_pkg::div_req_t            div_req;
    logic                          div_done;
    logic [lirs_pkg::RATE_W-1:0]   div_quot;
    logic [lirs_pkg::RATE_W-1:0]   div_rem;

    logic [lirs_pkg::RATE_W-1:0]   eff_snd_reg, eff_snd_next;
    logic [lirs_pkg::RATE_W-1:0]   eff_out_reg, eff_out_next;
    logic [lirs_pkg::RATE_W-1:0]   step_w_reg, step_w_next;
    logic [lirs_pkg::RATE_W-1:0]   step_r_reg, step_r_next;
    logic [lirs_pkg::SMP_W-1:0]    prev_reg, prev_next;
    logic [lirs_pkg::SMP_W-1:0]    x_reg, x_next;
    logic [lirs_pkg::SMP_W-1:0]    a_reg, a_next;
    logic [lirs_pkg::IDX_W-1:0]    index_reg, index_next;
    logic                          end_reg, end_next;
    lirs_pkg::pos_t                next_pos_reg, next_pos_next;
    lirs_pkg::pos_t                emit_pos_reg, emit_pos_next;
    lirs_pkg::pos_t                probe_reg, probe_next;
    lirs_pkg::pos_t                probe2_reg, probe2_next;
    logic                          f1_reg, f1_next;
    logic                          emitted_reg, emitted_next;
    logic [lirs_pkg::SMP_W-1:0]    held_reg [lirs_pkg::HOLD_DEPTH];
    logic [lirs_pkg::SMP_W-1:0]    held_next [lirs_pkg::HOLD_DEPTH];
    logic [lirs_pkg::HOLD_CW-1:0]  held_cnt_reg, held_cnt_next;
    logic                          neg_reg, neg_next;
    logic [lirs_pkg::PROD_W-1:0]   prod_reg, prod_next;
    logic                          out_valid_reg, out_valid_next;
    logic [lirs_pkg::SMP_W-1:0]    out_data_reg, out_data_next;
    logic                          out_last_reg, out_last_next;

    lirs_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quot  (div_quot),
        .rem   (div_rem)
    );

    always_comb
    begin
        logic [lirs_pkg::LIM_W-1:0]   n;
        logic                          slot_free;
        logic                          emit_now;
        logic                          emit_last;
        logic                          f2;
        logic                          first;
        logic                          cond;
        logic                          pos_zero;
        logic                          below_k;
        logic [lirs_pkg::SMP_W:0]      diff;
        logic [lirs_pkg::SMP_W:0]      mag;
        logic [lirs_pkg::SMP_W:0]      q;
        logic [lirs_pkg::SMP_W+1:0]    sum;
        logic [lirs_pkg::RATE_W-1:0]   snd_e;
        logic [lirs_pkg::RATE_W-1:0]   out_e;
        logic [lirs_pkg::RATE_W+4:0]   lim24;

        n         = lirs_pkg::LIM_W'(index_reg) + lirs_pkg::LIM_W'(1);
        slot_free = !out_valid_reg || out_ready;
        emit_now  = 1'b0;
        emit_last = 1'b0;
        f2        = lirs_pkg::pos_fits(probe2_reg, n);
        first     = (emit_pos_reg == '0) && !emitted_reg;
        pos_zero  = (next_pos_reg == '0);
        below_k   = next_pos_reg.w < lirs_pkg::POS_W'(index_reg);
        cond      = 1'b0;
        diff      = {x_reg[lirs_pkg::SMP_W-1], x_reg} - {a_reg[lirs_pkg::SMP_W-1], a_reg};
        mag       = diff[lirs_pkg::SMP_W] ? (~diff + 1'b1) : diff;
        q         = {1'b0, div_quot[lirs_pkg::SMP_W-1:0]};
        if (neg_reg)
        begin
            q = ~(q + lirs_pkg::SMP_W'(div_rem != '0)) + 1'b1;
        end
        sum       = {{2{a_reg[lirs_pkg::SMP_W-1]}}, a_reg} + {q[lirs_pkg::SMP_W], q};
        snd_e     = (cfg.sender_rate == '0) ? lirs_pkg::RATE_W'(1) : cfg.sender_rate;
        out_e     = (cfg.output_rate == '0) ? lirs_pkg::RATE_W'(1) : cfg.output_rate;
        lim24     = (lirs_pkg::RATE_W+5)'(snd_e) * (lirs_pkg::RATE_W+5)'(lirs_pkg::MAX_UPSAMPLE);
        if ((lirs_pkg::RATE_W+5)'(out_e) > lim24)
        begin
            out_e = lim24[lirs_pkg::RATE_W-1:0];
        end

        state_next    = state_reg;
        eff_snd_next  = eff_snd_reg;
        eff_out_next  = eff_out_reg;
        step_w_next   = step_w_reg;
        step_r_next   = step_r_reg;
        prev_next     = prev_reg;
        x_next        = x_reg;
        a_next        = a_reg;
        index_next    = index_reg;
        end_next      = end_reg;
        next_pos_next = next_pos_reg;
        emit_pos_next = emit_pos_reg;
        probe_next    = probe_reg;
        probe2_next   = probe2_reg;
        f1_next       = f1_reg;
        emitted_next  = emitted_reg;
        held_next     = held_reg;
        held_cnt_next = held_cnt_reg;
        neg_next      = neg_reg;
        prod_next     = prod_reg;

        div_req          = '0;
        div_req.divisor  = eff_out_reg;

        unique case (state_reg)
            lirs_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    x_next     = in_sample;
                    end_next   = in_end ||
                                 (index_reg == lirs_pkg::IDX_W'(lirs_pkg::MAX_BLOCK - 1));
                    state_next = lirs_pkg::ST_DR_A;
                end
            end
            lirs_pkg::ST_RC_EFF:
            begin
                eff_snd_next = snd_e;
                eff_out_next = out_e;
                state_next   = lirs_pkg::ST_RC_DIV;
            end
            lirs_pkg::ST_RC_DIV:
            begin
                div_req.start    = 1'b1;
                div_req.rem_init = '0;
                div_req.dividend = eff_snd_reg;
                div_req.iters    = lirs_pkg::DIV_STEP_ITERS;
                state_next       = lirs_pkg::ST_RC_WAIT;
            end
            lirs_pkg::ST_RC_WAIT:
            begin
                if (div_done)
                begin
                    step_w_next = div_quot;
                    step_r_next = div_rem;
                    state_next  = lirs_pkg::ST_IDLE;
                end
            end
            lirs_pkg::ST_DR_A:
            begin
                if (held_cnt_reg == '0)
                begin
                    state_next = lirs_pkg::ST_CK_A;
                end
                else
                begin
                    probe_next = lirs_pkg::pos_advance(emit_pos_reg, step_w_reg,
                                                       step_r_reg, eff_out_reg);
                    state_next = lirs_pkg::ST_DR_B;
                end
            end
            lirs_pkg::ST_DR_B:
            begin
                f1_next     = lirs_pkg::pos_fits(probe_reg, n);
                probe2_next = lirs_pkg::pos_advance(probe_reg, step_w_reg,
                                                    step_r_reg, eff_out_reg);
                state_next  = lirs_pkg::ST_DR_C;
            end
            lirs_pkg::ST_DR_C:
            begin
                priority if (!end_reg && !f2)
                begin
                    state_next = lirs_pkg::ST_CK_A;
                end
                else if (end_reg && !f1_reg && !first)
                begin
                    held_cnt_next = '0;
                    state_next    = lirs_pkg::ST_CK_A;
                end
                else if (slot_free)
                begin
                    emit_now  = 1'b1;
                    emit_last = end_reg && !f2;
                    for (int i = 0; i < lirs_pkg::HOLD_DEPTH - 1; i++)
                    begin
                        held_next[i] = held_reg[i+1];
                    end
                    held_cnt_next = held_cnt_reg - lirs_pkg::HOLD_CW'(1);
                    emit_pos_next = probe_reg;
                    emitted_next  = 1'b1;
                    state_next    = lirs_pkg::ST_DR_A;
                end
                else
                begin
                    state_next = lirs_pkg::ST_DR_C;
                end
            end
            lirs_pkg::ST_CK_A:
            begin
                probe_next = lirs_pkg::pos_advance(next_pos_reg, step_w_reg,
                                                   step_r_reg, eff_out_reg);
                state_next = lirs_pkg::ST_CK_B;
            end
            lirs_pkg::ST_CK_B:
            begin
                if (end_reg)
                begin
                    cond = (next_pos_reg.w <= lirs_pkg::POS_W'(index_reg)) &&
                           (held_cnt_reg < lirs_pkg::HOLD_CW'(lirs_pkg::HOLD_DEPTH)) &&
                           (lirs_pkg::pos_fits(probe_reg, n) || pos_zero);
                end
                else
                begin
                    cond = below_k &&
                           (held_cnt_reg < lirs_pkg::HOLD_CW'(lirs_pkg::HOLD_DEPTH));
                end
                if (cond)
                begin
                    a_next     = below_k ? prev_reg : x_reg;
                    state_next = lirs_pkg::ST_MUL;
                end
                else if (!end_reg)
                begin
                    prev_next  = x_reg;
                    index_next = index_reg + lirs_pkg::IDX_W'(1);
                    state_next = lirs_pkg::ST_IDLE;
                end
                else
                begin
                    prev_next     = '0;
                    index_next    = '0;
                    next_pos_next = '0;
                    emit_pos_next = '0;
                    emitted_next  = 1'b0;
                    held_cnt_next = '0;
                    state_next    = lirs_pkg::ST_IDLE;
                end
            end
            lirs_pkg::ST_MUL:
            begin
                neg_next   = diff[lirs_pkg::SMP_W];
                prod_next  = lirs_pkg::PROD_W'(mag[lirs_pkg::SMP_W-1:0]) *
                             lirs_pkg::PROD_W'(next_pos_reg.r);
                state_next = lirs_pkg::ST_DIV;
            end
            lirs_pkg::ST_DIV:
            begin
                div_req.start    = 1'b1;
                div_req.rem_init = prod_reg[lirs_pkg::PROD_W-1:lirs_pkg::SMP_W];
                div_req.dividend = {prod_reg[lirs_pkg::SMP_W-1:0],
                                    (lirs_pkg::RATE_W-lirs_pkg::SMP_W)'(0)};
                div_req.iters    = lirs_pkg::DIV_INTERP_ITERS;
                state_next       = lirs_pkg::ST_DIV_WAIT;
            end
            lirs_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    held_next[held_cnt_reg[lirs_pkg::HOLD_IW-1:0]] =
                        sum[lirs_pkg::SMP_W-1:0];
                    held_cnt_next = held_cnt_reg + lirs_pkg::HOLD_CW'(1);
                    next_pos_next = probe_reg;
                    state_next    = lirs_pkg::ST_DR_A;
                end
            end
            default:
            begin
                state_next = lirs_pkg::ST_IDLE;
            end
        endcase

        if (cfg.wr)
        begin
            prev_next     = '0;
            index_next    = '0;
            next_pos_next = '0;
            emit_pos_next = '0;
            emitted_next  = 1'b0;
            held_cnt_next = '0;
            state_next    = lirs_pkg::ST_RC_EFF;
        end

        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        if (emit_now)
        begin
            out_valid_next = 1'b1;
            out_data_next  = held_reg[0];
            out_last_next  = emit_last;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lirs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_snd_reg   <= lirs_pkg::RATE_RESET;
            eff_out_reg   <= lirs_pkg::RATE_RESET;
            step_w_reg    <= lirs_pkg::RATE_W'(1);
            step_r_reg    <= '0;
            prev_reg      <= '0;
            x_reg         <= '0;
            a_reg         <= '0;
            index_reg     <= '0;
            end_reg       <= 1'b0;
            next_pos_reg  <= '0;
            emit_pos_reg  <= '0;
            probe_reg     <= '0;
            probe2_reg    <= '0;
            f1_reg        <= 1'b0;
            emitted_reg   <= 1'b0;
            held_cnt_reg  <= '0;
            neg_reg       <= 1'b0;
            prod_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_last_reg  <= 1'b0;
            for (int i = 0; i < lirs_pkg::HOLD_DEPTH; i++)
            begin
                held_reg[i] <= '0;
            end
        end
        else
        begin
            eff_snd_reg   <= eff_snd_next;
            eff_out_reg   <= eff_out_next;
            step_w_reg    <= step_w_next;
            step_r_reg    <= step_r_next;
            prev_reg      <= prev_next;
            x_reg         <= x_next;
            a_reg         <= a_next;
            index_reg     <= index_next;
            end_reg       <= end_next;
            next_pos_reg  <= next_pos_next;
            emit_pos_reg  <= emit_pos_next;
            probe_reg     <= probe_next;
            probe2_reg    <= probe2_next;
            f1_reg        <= f1_next;
            emitted_reg   <= emitted_next;
            held_cnt_reg  <= held_cnt_next;
            neg_reg       <= neg_next;
            prod_reg      <= prod_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            out_last_reg  <= out_last_next;
            held_reg      <= held_next;
        end
    end

    assign in_ready   = (state_reg == lirs_pkg::ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_sample = out_data_reg;
    assign out_last   = out_last_reg;

endmodule

>>> hdl/linear_interpolation_resampler_top.sv
// Each input beat passes through the sequencer, which runs one multiply and a 16-step serial
// divide for each output it computes and emits; the beat after it is taken once the
// sequencer is back in idle. A rate write starts a step recompute (18-step serial divide)
// with the sample input held off.
// Reset: rst_n is asynchronous; both rates return to 48000, the step to 1, the block
// state and the output register are cleared.
module linear_interpolation_resampler_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] in_sample
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] out_sample
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [lirs_pkg::RATE_W-1:0] snd_rate_reg, snd_rate_next;
    logic [lirs_pkg::RATE_W-1:0] out_rate_reg, out_rate_next;
    logic                        wr;
    logic                        reg_sel;
    lirs_pkg::cfg_t              cfg;

    assign pready  = 1'b1;
    assign wr      = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];

    always_comb
    begin
        snd_rate_next = snd_rate_reg;
        out_rate_next = out_rate_reg;
        if (wr)
        begin
            unique case (reg_sel)
                1'(lirs_pkg::REG_SENDER_RATE):
                begin
                    snd_rate_next = pwdata[lirs_pkg::RATE_W-1:0];
                end
                1'(lirs_pkg::REG_OUTPUT_RATE):
                begin
                    out_rate_next = pwdata[lirs_pkg::RATE_W-1:0];
                end
                default:
                begin
                    snd_rate_next = snd_rate_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snd_rate_reg <= lirs_pkg::RATE_RESET;
            out_rate_reg <= lirs_pkg::RATE_RESET;
        end
        else
        begin
            snd_rate_reg <= snd_rate_next;
            out_rate_reg <= out_rate_next;
        end
    end

    assign prdata = (reg_sel == 1'(lirs_pkg::REG_OUTPUT_RATE)) ?
                    32'(out_rate_reg) : 32'(snd_rate_reg);

    always_comb
    begin
        cfg.wr          = wr;
        cfg.sender_rate = snd_rate_reg;
        cfg.output_rate = out_rate_reg;
    end

    lirs_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_sample  (s_axis_tdata),
        .in_end     (s_axis_tlast),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_sample (m_axis_tdata),
        .out_last   (m_axis_tlast)
    );

endmodule
